// File: src/lxrwc_pkg.sv
// Shared types, constants and codes for the LCG XOR-rotate word cipher.
package lxrwc_pkg;

  localparam logic [31:0] LcgMul = 32'd1664525;
  localparam logic [31:0] LcgAdd = 32'd1013904223;
  // floor(y / 3) == (y * Recip3) >> 13 for every 13-bit y
  localparam logic [11:0] Recip3 = 12'd2731;

  typedef enum logic [0:0] {
    REG_CIPHER_KEY   = 1'b0,
    REG_DECRYPT_MODE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_MOD,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic        start_msg;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic [2:0]  result_count;
  } out_item_t;

endpackage

// File: src/lxrwc_lcg.sv
// Generator seed register with its single multiply-add step unit.
module lxrwc_lcg (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [31:0] load_value,
  input  logic        step,
  output logic [31:0] seed_adv
);
  import lxrwc_pkg::*;

  logic [31:0] seed;

  assign seed_adv = seed * LcgMul + LcgAdd;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (load) begin
      seed <= load_value;
    end else if (step) begin
      seed <= seed_adv;
    end
  end

endmodule

// File: src/lcg_xor_rotate_word_cipher.sv
// Top level of the LCG XOR-rotate word cipher.
// One word of byte_count bytes (1 to 4) is taken while the block is idle; the
// generator then advances one multiply-add step per cycle in ST_DRAW, with
// one draw for polarity, one for the rotate amount and one per key byte.
// ST_MOD then reduces the rotate amount and ST_CALC does the XOR and rotate
// into the output register; the block goes back to idle before it takes the
// next word, so a new word is not taken until the last one is through.
// A count of zero skips the draws and ST_MOD and goes straight to ST_CALC.
// The result only leaves the last stage once the output register is free. The
// block takes the next word while a finished result still waits in the output
// register.
module lcg_xor_rotate_word_cipher (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lxrwc_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lxrwc_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  lxrwc_pkg::cfg_reg_t  cfg_index,
  input  logic [31:0]          cfg_data
);
  import lxrwc_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [31:0] cipher_key;
  logic        decrypt_mode;
  logic [2:0]  cnt;
  logic [2:0]  idx;
  logic [31:0] x;
  logic [31:0] key;
  logic        pol;
  logic [15:0] amt_raw;
  logic [4:0]  amt;
  logic [31:0] seed_adv;

  logic        in_acc;
  logic        out_free;
  logic        gen_step;
  logic [2:0]  in_cnt;
  logic [31:0] in_mask;
  logic [31:0] mask;
  logic [5:0]  width;
  logic [12:0] hi13;
  logic [24:0] prod3;
  logic [11:0] quot3;
  logic [12:0] rem3;
  logic [4:0]  amt_mod;
  logic        rot_left;
  logic [31:0] pre;
  logic [63:0] dbl;
  logic [5:0]  shamt;
  logic [63:0] shifted;
  logic [31:0] rot;
  logic [31:0] res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign gen_step  = (state == ST_DRAW);

  lxrwc_lcg u_lcg (
    .clk        (clk),
    .rst        (rst),
    .load       (in_acc && in_item.start_msg),
    .load_value (cipher_key),
    .step       (gen_step),
    .seed_adv   (seed_adv)
  );

  // saturate count above four
  assign in_cnt = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;

  always_comb begin
    unique case (in_cnt)
      3'd1:    in_mask = 32'h0000_00ff;
      3'd2:    in_mask = 32'h0000_ffff;
      3'd3:    in_mask = 32'h00ff_ffff;
      3'd4:    in_mask = 32'hffff_ffff;
      default: in_mask = 32'h0000_0000;
    endcase
  end

  always_comb begin
    unique case (cnt)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      3'd4:    mask = 32'hffff_ffff;
      default: mask = 32'h0000_0000;
    endcase
  end

  assign width = {cnt, 3'b000};

  // amount modulo 24: 8 * ((raw >> 3) mod 3) + (raw & 7)
  assign hi13  = amt_raw[15:3];
  assign prod3 = {12'b0, hi13} * {13'b0, Recip3};
  assign quot3 = prod3[24:13];
  assign rem3  = hi13 - {quot3, 1'b0} - {1'b0, quot3};

  always_comb begin
    unique case (cnt)
      3'd1:    amt_mod = {2'b00, amt_raw[2:0]};
      3'd2:    amt_mod = {1'b0, amt_raw[3:0]};
      3'd3:    amt_mod = {rem3[1:0], amt_raw[2:0]};
      default: amt_mod = amt_raw[4:0];
    endcase
  end

  // rotate within width bits by shifting a doubled copy right
  assign rot_left = decrypt_mode ? !pol : pol;
  assign pre      = decrypt_mode ? x : (x ^ key);
  assign dbl      = {32'b0, pre} | ({32'b0, pre} << width);
  assign shamt    = rot_left ? (width - {1'b0, amt}) : {1'b0, amt};
  assign shifted  = dbl >> shamt;
  assign rot      = shifted[31:0] & mask;
  assign res      = decrypt_mode ? (rot ^ key) : rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (in_cnt == 3'd0) ? ST_CALC : ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (idx == cnt + 3'd1) begin
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key   <= '0;
      decrypt_mode <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CIPHER_KEY:   cipher_key   <= cfg_data;
          REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
          default:          ;
        endcase
      end
      if (state == ST_CALC && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt <= in_cnt;
      x   <= in_item.data_word & in_mask;
      key <= '0;
      amt <= '0;
      pol <= 1'b0;
      idx <= '0;
    end
    if (state == ST_DRAW) begin
      idx <= idx + 3'd1;
      priority if (idx == 3'd0) begin
        pol <= seed_adv[16];
      end else if (idx == 3'd1) begin
        amt_raw <= seed_adv[31:16];
      end else begin
        // first key byte drawn ends up most significant
        key <= {key[23:0], seed_adv[23:16]};
      end
    end
    if (state == ST_MOD) begin
      amt <= amt_mod;
    end
    if (state == ST_CALC && out_free) begin
      out_item.result_word  <= res;
      out_item.result_count <= cnt;
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the LCG XOR-rotate word cipher.
`timescale 1ns / 100ps

module testbench;
  import lxrwc_pkg::*;

  localparam logic [31:0] SeedMul = 32'd1664525;
  localparam logic [31:0] SeedAdd = 32'd1013904223;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 186;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [31:0] cfg_data;

  in_item_t    pend_words[$];
  out_item_t   expected_words[$];

  logic [31:0] gen_state;
  logic [31:0] key_shadow;
  logic        decrypt_shadow;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned err_count;
  logic        hold_arm;
  logic        hold_on;

  lcg_xor_rotate_word_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // advance the generator one step and draw from its upper half
  function automatic int unsigned lcg_draw(int unsigned n);
    gen_state = gen_state * SeedMul + SeedAdd;
    return int'(gen_state[31:16]) % n;
  endfunction

  function automatic out_item_t cipher_word(in_item_t it);
    out_item_t   res;
    int unsigned cnt;
    int unsigned w;
    int unsigned pol;
    int unsigned amt;
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] key;
    logic [63:0] rl;
    logic [63:0] rr;
    res = '0;
    cnt = it.byte_count;
    if (it.start_msg) begin
      gen_state = key_shadow;
    end
    if (cnt > 4) begin
      cnt = 4;
    end
    if (cnt == 0) begin
      return res;
    end
    w = 8 * cnt;
    mask = (64'd1 << w) - 64'd1;
    x = {32'd0, it.data_word} & mask;
    pol = lcg_draw(2);
    amt = lcg_draw(w);
    key = '0;
    // first key byte lands in the most significant byte in use
    for (int unsigned i = 0; i < cnt; i++) begin
      key = (key << 8) | 64'(lcg_draw(256) & 8'hff);
    end
    if (!decrypt_shadow) begin
      x = x ^ key;
    end
    rl = ((x << amt) | (x >> (w - amt))) & mask;
    rr = ((x >> amt) | (x << (w - amt))) & mask;
    if (!decrypt_shadow) begin
      x = (pol != 0) ? rl : rr;
    end else begin
      x = ((pol != 0) ? rr : rl) ^ key;
    end
    res.result_word = x[31:0];
    res.result_count = 3'(cnt);
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // driver: hold a stalled item, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(cipher_word(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (pend_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pend_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word=%08h count=%0d",
                                  out_item.result_word, out_item.result_count));
        end else begin
          out_item_t exp_word;
          exp_word = expected_words.pop_front();
          if (out_item.result_word !== exp_word.result_word) begin
            flag_mismatch($sformatf("result_word got %08h want %08h",
                                    out_item.result_word, exp_word.result_word));
          end
          if (out_item.result_count !== exp_word.result_count) begin
            flag_mismatch($sformatf("result_count got %0d want %0d",
                                    out_item.result_count, exp_word.result_count));
          end
        end
      end
      out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    hold_on = 1'b0;
    wait (hold_arm);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (HoldCycles) @(negedge clk);
    hold_on = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CIPHER_KEY) begin
      key_shadow = val;
    end else begin
      decrypt_shadow = val[0];
    end
  endtask

  task automatic push_word(logic start, logic [31:0] data, logic [2:0] cnt);
    in_item_t it;
    it.start_msg = start;
    it.data_word = data;
    it.byte_count = cnt;
    pend_words.push_back(it);
  endtask

  function automatic logic [31:0] pick_data();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // mostly well-formed messages with random content, some noise words
  task automatic queue_random(int unsigned n_items);
    int unsigned left;
    int unsigned len;
    logic [2:0]  cnt;
    left = n_items;
    while (left != 0) begin
      if ($urandom_range(9) != 0) begin
        len = $urandom_range(8, 1);
        for (int unsigned i = 0; i < len && left != 0; i++) begin
          if (i == len - 1) begin
            cnt = 3'($urandom_range(4, 1));
          end else if ($urandom_range(19) == 0) begin
            cnt = 3'($urandom_range(3, 1));
          end else begin
            cnt = 3'd4;
          end
          push_word(i == 0, pick_data(), cnt);
          left--;
        end
      end else begin
        push_word(1'($urandom_range(1)), pick_data(), 3'($urandom_range(7)));
        left--;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pend_words.size() != 0 || in_valid || expected_words.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin
    logic [31:0] zero_rot_key;
    logic [31:0] s;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_CIPHER_KEY;
    cfg_data = '0;
    gen_state = '0;
    key_shadow = '0;
    decrypt_shadow = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    err_count = 0;
    hold_arm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // find a key whose first full word rotates by zero
    zero_rot_key = $urandom();
    forever begin
      s = zero_rot_key * SeedMul + SeedAdd;
      s = s * SeedMul + SeedAdd;
      if (s[31:16] % 32 == 0) begin
        break;
      end
      zero_rot_key++;
    end

    // directed words
    write_reg(REG_CIPHER_KEY, zero_rot_key);
    write_reg(REG_DECRYPT_MODE, 32'd0);
    push_word(1'b1, 32'h0000_0000, 3'd4);
    push_word(1'b0, 32'hffff_ffff, 3'd4);
    push_word(1'b0, 32'h1234_5678, 3'd4);
    push_word(1'b1, 32'hffff_ffff, 3'd1);
    push_word(1'b0, 32'ha5a5_a5a5, 3'd2);
    push_word(1'b0, 32'h5a5a_5a5a, 3'd3);
    push_word(1'b0, 32'hffff_ffff, 3'd0);
    push_word(1'b1, 32'h0000_0000, 3'd0);
    push_word(1'b0, 32'h0000_0001, 3'd4);
    push_word(1'b0, 32'hdead_beef, 3'd5);
    push_word(1'b0, 32'h8000_0001, 3'd6);
    push_word(1'b0, 32'hffff_ffff, 3'd7);
    push_word(1'b1, 32'h0102_0304, 3'd2);
    push_word(1'b0, 32'hcafe_f00d, 3'd4);
    push_word(1'b0, 32'h0000_0000, 3'd4);
    push_word(1'b0, 32'hffff_ff00, 3'd1);
    push_word(1'b1, 32'h00ff_00ff, 3'd3);
    push_word(1'b1, 32'h7fff_ffff, 3'd4);
    push_word(1'b0, 32'h8000_0000, 3'd4);
    push_word(1'b0, 32'hffff_ffff, 3'd2);
    wait_idle();

    write_reg(REG_CIPHER_KEY, 32'h0000_0000);
    queue_random(PhaseItems);
    wait_idle();

    write_reg(REG_CIPHER_KEY, 32'hffff_ffff);
    write_reg(REG_DECRYPT_MODE, 32'd1);
    send_idle_pct = 61;
    queue_random(PhaseItems);
    wait_idle();

    write_reg(REG_CIPHER_KEY, $urandom());
    write_reg(REG_DECRYPT_MODE, 32'd0);
    send_idle_pct = 0;
    recv_stall_pct = 61;
    queue_random(PhaseItems);
    wait_idle();

    write_reg(REG_CIPHER_KEY, $urandom());
    write_reg(REG_DECRYPT_MODE, 32'd1);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    queue_random(PhaseItems);
    wait_idle();

    // hold the output long enough to back up the input
    write_reg(REG_CIPHER_KEY, $urandom());
    write_reg(REG_DECRYPT_MODE, 32'($urandom_range(1)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(PhaseItems);
    hold_arm = 1'b1;
    wait_idle();

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/lxrwc_pkg.sv
src/lxrwc_lcg.sv
src/lcg_xor_rotate_word_cipher.sv
tb/testbench.sv
